FILE: hdl/saw_rx_pkg.sv
// Package with the types, codes and checksum helper of the stop-and-wait receiver.
package saw_rx_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned HdrLen     = 6;
  localparam int unsigned PktMax     = HdrLen + MaxPayload;
  localparam logic [10:0] CntSat     = 11'd2047;

  localparam logic [7:0] FlagData = 8'h00;
  localparam logic [7:0] FlagAck  = 8'h02;
  localparam logic [7:0] FlagOver = 8'h07;

  localparam logic [2:0] StatAccepted   = 3'd0;
  localparam logic [2:0] StatOutOfOrder = 3'd1;
  localparam logic [2:0] StatOver       = 3'd2;
  localparam logic [2:0] StatBadSum     = 3'd3;
  localparam logic [2:0] StatOtherFlag  = 3'd4;
  localparam logic [2:0] StatShort      = 3'd5;
  localparam logic [2:0] StatLong       = 3'd6;

  localparam logic [15:0] SumGood = 16'hffff;
  localparam logic [31:0] TotalMax = 32'hffff_ffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  packet_status;
    logic        send_response;
    logic [7:0]  reply_flag;
    logic [7:0]  reply_seq;
    logic [15:0] reply_size;
    logic [15:0] reply_checksum;
    logic        payload_commit;
    logic [31:0] total_received;
  } out_t;

  // One's-complement addition with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[16] ? 16'(s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

FILE: hdl/stop_and_wait_receiver.sv
// Stop-and-wait receiver: checksum, classification and response of received datagrams.

// Datagram bytes arrive as transfers on the input channel, header first, with last_byte
// set on the final byte. Each transfer is registered and then processed from the register,
// so one byte is taken every clock while the result side is not stalled; the only
// hold-off is a final byte waiting for the result register to be free. Exactly one
// result transfer is produced per datagram; it is loaded into the result register when
// its final byte is processed. The whole datagram, with an odd final byte padded by
// zero, is checked against a one's-complement sum of all ones.
module stop_and_wait_receiver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  saw_rx_pkg::in_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output saw_rx_pkg::out_t  out_o
);

  logic             in_valid_q;
  saw_rx_pkg::in_t  in_q;
  logic             out_valid_q;
  saw_rx_pkg::out_t out_q;

  logic [10:0] byte_count_q, byte_count_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  flag_q, flag_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [31:0] total_q, total_d;

  logic             out_free;
  logic             proc_en;
  logic [15:0]      final_sum;
  logic [32:0]      total_add;
  logic [31:0]      total_sat;
  saw_rx_pkg::out_t res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc_en    = in_valid_q && (!in_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || proc_en;

  assign total_add = {1'b0, total_q} + {17'd0, size_d};
  assign total_sat = total_add[32] ? saw_rx_pkg::TotalMax : total_add[31:0];

  always_comb begin
    byte_count_d = byte_count_q;
    sum_d        = sum_q;
    held_d       = held_q;
    size_d       = size_q;
    flag_d       = flag_q;
    seq_d        = seq_q;
    exp_seq_d    = exp_seq_q;
    total_d      = total_q;
    if (byte_count_q < saw_rx_pkg::CntSat) begin
      if (!byte_count_q[0]) begin
        held_d = in_q.data_byte;
      end else begin
        sum_d = saw_rx_pkg::oc_add(sum_q, {in_q.data_byte, held_q});
      end
      if (byte_count_q == 11'd2) size_d[7:0]  = in_q.data_byte;
      if (byte_count_q == 11'd3) size_d[15:8] = in_q.data_byte;
      if (byte_count_q == 11'd4) flag_d       = in_q.data_byte;
      if (byte_count_q == 11'd5) seq_d        = in_q.data_byte;
      byte_count_d = byte_count_q + 11'd1;
    end

    final_sum = sum_d;
    if (byte_count_d[0] && byte_count_d < saw_rx_pkg::CntSat) begin
      final_sum = saw_rx_pkg::oc_add(sum_d, {8'd0, held_d});
    end

    res                = '0;
    res.total_received = total_q;
    if (32'(byte_count_d) < saw_rx_pkg::HdrLen) begin
      res.packet_status = saw_rx_pkg::StatShort;
    end else if (byte_count_d >= saw_rx_pkg::CntSat ||
                 32'(byte_count_d) > saw_rx_pkg::PktMax) begin
      res.packet_status = saw_rx_pkg::StatLong;
    end else if (final_sum != saw_rx_pkg::SumGood) begin
      res.packet_status = saw_rx_pkg::StatBadSum;
    end else if (flag_d == saw_rx_pkg::FlagData) begin
      res.send_response = 1'b1;
      res.reply_flag    = saw_rx_pkg::FlagAck;
      if (seq_d == exp_seq_q) begin
        res.packet_status  = saw_rx_pkg::StatAccepted;
        res.payload_commit = 1'b1;
        res.reply_seq      = seq_d;
        res.total_received = total_sat;
        total_d            = total_sat;
        exp_seq_d          = exp_seq_q + 8'd1;
      end else begin
        res.packet_status = saw_rx_pkg::StatOutOfOrder;
        res.reply_seq     = exp_seq_q;
      end
      res.reply_checksum = ~{res.reply_seq, saw_rx_pkg::FlagAck};
    end else if (flag_d == saw_rx_pkg::FlagOver) begin
      res.packet_status  = saw_rx_pkg::StatOver;
      res.send_response  = 1'b1;
      res.reply_flag     = saw_rx_pkg::FlagOver;
      res.reply_seq      = seq_d;
      res.reply_size     = size_d;
      res.reply_checksum = ~saw_rx_pkg::oc_add(size_d, {seq_d, saw_rx_pkg::FlagOver});
      exp_seq_d          = '0;
      total_d            = '0;
    end else begin
      res.packet_status = saw_rx_pkg::StatOtherFlag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      sum_q        <= '0;
      held_q       <= '0;
      size_q       <= '0;
      flag_q       <= '0;
      seq_q        <= '0;
      exp_seq_q    <= '0;
      total_q      <= '0;
    end else if (proc_en) begin
      if (in_q.last_byte) begin
        byte_count_q <= '0;
        sum_q        <= '0;
        held_q       <= '0;
        size_q       <= '0;
        flag_q       <= '0;
        seq_q        <= '0;
      end else begin
        byte_count_q <= byte_count_d;
        sum_q        <= sum_d;
        held_q       <= held_d;
        size_q       <= size_d;
        flag_q       <= flag_d;
        seq_q        <= seq_d;
      end
      exp_seq_q <= in_q.last_byte ? exp_seq_d : exp_seq_q;
      total_q   <= in_q.last_byte ? total_d : total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_en && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && in_q.last_byte) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en && in_q.last_byte) |=> (byte_count_q == '0 && sum_q == '0))
    else $error("per-datagram state not cleared after final byte");

  a_commit_only_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.payload_commit) |->
      (out_o.packet_status == saw_rx_pkg::StatAccepted))
    else $error("payload committed for a datagram that was not accepted");

  a_response_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.send_response) |->
      (out_o.reply_flag == saw_rx_pkg::FlagAck || out_o.reply_flag == saw_rx_pkg::FlagOver))
    else $error("response carries an unexpected flag");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en && in_q.last_byte) |-> out_free)
    else $error("result register overwritten while a result is pending");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the stop-and-wait receiver with its own packet-verdict predictor.
`timescale 1ns / 1ps

module testbench;
  import saw_rx_pkg::*;

  typedef struct {
    in_t        item;
    bit         typed;
    logic [2:0] status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  bit quiet = 1'b0;
  int unsigned n_mismatch = 0;
  int unsigned n_in = 0;
  int unsigned rand_bytes = 0;

  out_t verdict_q[$];
  dir_row_t dir_rows[$];
  logic [7:0] dgram[$];
  logic [7:0] gen_seq = '0;

  logic [10:0] rx_count = '0;
  logic [15:0] rx_sum = '0;
  logic [7:0]  rx_low = '0;
  logic [15:0] rx_size = '0;
  logic [7:0]  rx_flag = '0;
  logic [7:0]  rx_seq = '0;
  logic [7:0]  want_seq = '0;
  logic [31:0] rx_total = '0;

  stop_and_wait_receiver dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] t;
    t = {1'b0, x} + {1'b0, y};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [15:0] header_sum(input logic [15:0] size, input logic [7:0] flag,
                                             input logic [7:0] seq);
    return ~ones_add(size, {seq, flag});
  endfunction

  task automatic classify_byte(input in_t it, output bit done, output out_t v);
    logic [10:0] cnt;
    logic [15:0] s;
    done = 1'b0;
    v = '0;
    if (rx_count < CntSat) begin
      if (!rx_count[0]) begin
        rx_low = it.data_byte;
      end else begin
        rx_sum = ones_add(rx_sum, {it.data_byte, rx_low});
      end
      case (rx_count)
        11'd2: rx_size[7:0] = it.data_byte;
        11'd3: rx_size[15:8] = it.data_byte;
        11'd4: rx_flag = it.data_byte;
        11'd5: rx_seq = it.data_byte;
        default: ;
      endcase
      cnt = rx_count + 11'd1;
    end else begin
      cnt = CntSat;
    end
    rx_count = cnt;
    if (it.last_byte) begin
      s = rx_sum;
      if (cnt[0] && cnt < CntSat) begin
        s = ones_add(s, {8'h00, rx_low});
      end
      v.total_received = rx_total;
      if (cnt < HdrLen) begin
        v.packet_status = StatShort;
      end else if (cnt >= CntSat || cnt > PktMax) begin
        v.packet_status = StatLong;
      end else if (s != SumGood) begin
        v.packet_status = StatBadSum;
      end else if (rx_flag == FlagData) begin
        v.send_response = 1'b1;
        v.reply_flag = FlagAck;
        if (rx_seq == want_seq) begin
          v.packet_status = StatAccepted;
          v.payload_commit = 1'b1;
          v.reply_seq = rx_seq;
          if (rx_total > TotalMax - {16'h0000, rx_size}) begin
            rx_total = TotalMax;
          end else begin
            rx_total = rx_total + {16'h0000, rx_size};
          end
          want_seq = want_seq + 8'd1;
          v.total_received = rx_total;
        end else begin
          v.packet_status = StatOutOfOrder;
          v.reply_seq = want_seq;
        end
        v.reply_checksum = header_sum(16'h0000, FlagAck, v.reply_seq);
      end else if (rx_flag == FlagOver) begin
        v.packet_status = StatOver;
        v.send_response = 1'b1;
        v.reply_flag = FlagOver;
        v.reply_seq = rx_seq;
        v.reply_size = rx_size;
        v.reply_checksum = header_sum(rx_size, FlagOver, rx_seq);
        want_seq = '0;
        rx_total = '0;
      end else begin
        v.packet_status = StatOtherFlag;
      end
      done = 1'b1;
      rx_count = '0;
      rx_sum = '0;
      rx_low = '0;
      rx_size = '0;
      rx_flag = '0;
      rx_seq = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (n_mismatch < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    bit   done;
    out_t v;
    out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        classify_byte(in_item, done, v);
        if (done) begin
          if (n_in < dir_rows.size() && dir_rows[n_in].typed) begin
            v = '0;
            v.packet_status = dir_rows[n_in].status;
          end
          verdict_q.push_back(v);
        end
        n_in++;
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with no verdict pending");
        end else begin
          e = verdict_q.pop_front();
          if (out_item.packet_status !== e.packet_status)
            report_mismatch($sformatf("packet_status %0h, want %0h",
                                      out_item.packet_status, e.packet_status));
          if (out_item.send_response !== e.send_response)
            report_mismatch($sformatf("send_response %0h, want %0h",
                                      out_item.send_response, e.send_response));
          if (out_item.reply_flag !== e.reply_flag)
            report_mismatch($sformatf("reply_flag %0h, want %0h",
                                      out_item.reply_flag, e.reply_flag));
          if (out_item.reply_seq !== e.reply_seq)
            report_mismatch($sformatf("reply_seq %0h, want %0h",
                                      out_item.reply_seq, e.reply_seq));
          if (out_item.reply_size !== e.reply_size)
            report_mismatch($sformatf("reply_size %0h, want %0h",
                                      out_item.reply_size, e.reply_size));
          if (out_item.reply_checksum !== e.reply_checksum)
            report_mismatch($sformatf("reply_checksum %0h, want %0h",
                                      out_item.reply_checksum, e.reply_checksum));
          if (out_item.payload_commit !== e.payload_commit)
            report_mismatch($sformatf("payload_commit %0h, want %0h",
                                      out_item.payload_commit, e.payload_commit));
          if (out_item.total_received !== e.total_received)
            report_mismatch($sformatf("total_received %0h, want %0h",
                                      out_item.total_received, e.total_received));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 13);
  end

  task automatic push_byte(input in_t it);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                         input logic [2:0] status);
    dir_row_t r;
    r.item.data_byte = b;
    r.item.last_byte = last;
    r.typed = typed;
    r.status = status;
    dir_rows.push_back(r);
  endtask

  task automatic build_datagram(input logic [15:0] size, input logic [7:0] flag,
                                input logic [7:0] seq, input int unsigned pay_len,
                                input bit corrupt);
    logic [15:0] s;
    logic [15:0] w;
    int unsigned k;
    dgram.delete();
    dgram.push_back(8'h00);
    dgram.push_back(8'h00);
    dgram.push_back(size[7:0]);
    dgram.push_back(size[15:8]);
    dgram.push_back(flag);
    dgram.push_back(seq);
    repeat (pay_len) dgram.push_back(8'($urandom_range(255)));
    s = '0;
    for (int i = 0; i < dgram.size(); i += 2) begin
      w = {(i + 1 < dgram.size()) ? dgram[i + 1] : 8'h00, dgram[i]};
      s = ones_add(s, w);
    end
    s = ~s;
    dgram[0] = s[7:0];
    dgram[1] = s[15:8];
    if (corrupt) begin
      k = $urandom_range(dgram.size() - 1);
      dgram[k] = dgram[k] ^ (8'h01 << $urandom_range(7));
    end
  endtask

  task automatic random_bytes(input int unsigned n);
    dgram.delete();
    repeat (n) dgram.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_datagram();
    in_t it;
    for (int i = 0; i < dgram.size(); i++) begin
      it.data_byte = dgram[i];
      it.last_byte = (i == dgram.size() - 1);
      push_byte(it);
    end
    rand_bytes += dgram.size();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned guard;
    logic [7:0]  f;

    add_row(8'hff, 1'b1, 1'b1, StatShort);
    add_row(8'h20, 1'b0, 1'b0, StatAccepted);
    add_row(8'hed, 1'b0, 1'b0, StatAccepted);
    add_row(8'h34, 1'b0, 1'b0, StatAccepted);
    add_row(8'h12, 1'b0, 1'b0, StatAccepted);
    add_row(8'h00, 1'b0, 1'b0, StatAccepted);
    add_row(8'h00, 1'b0, 1'b0, StatAccepted);
    add_row(8'hab, 1'b1, 1'b0, StatAccepted);
    add_row(8'hf8, 1'b0, 1'b0, StatOver);
    add_row(8'h00, 1'b0, 1'b0, StatOver);
    add_row(8'hff, 1'b0, 1'b0, StatOver);
    add_row(8'hff, 1'b0, 1'b0, StatOver);
    add_row(8'h07, 1'b0, 1'b0, StatOver);
    add_row(8'hff, 1'b1, 1'b0, StatOver);
    add_row(8'hfa, 1'b0, 1'b1, StatOtherFlag);
    add_row(8'hff, 1'b0, 1'b1, StatOtherFlag);
    add_row(8'h00, 1'b0, 1'b1, StatOtherFlag);
    add_row(8'h00, 1'b0, 1'b1, StatOtherFlag);
    add_row(8'h05, 1'b0, 1'b1, StatOtherFlag);
    add_row(8'h00, 1'b1, 1'b1, StatOtherFlag);
    add_row(8'h00, 1'b0, 1'b1, StatBadSum);
    add_row(8'h00, 1'b0, 1'b1, StatBadSum);
    add_row(8'h00, 1'b0, 1'b1, StatBadSum);
    add_row(8'h00, 1'b0, 1'b1, StatBadSum);
    add_row(8'h00, 1'b0, 1'b1, StatBadSum);
    add_row(8'h00, 1'b1, 1'b1, StatBadSum);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) push_byte(dir_rows[i].item);
    wait_drained();
    gen_seq = '0;

    // A datagram one byte longer than the largest accepted one, sent with no idling.
    quiet = 1'b1;
    build_datagram(16'($urandom_range(65535)), FlagData, gen_seq, MaxPayload + 1, 1'b0);
    send_datagram();
    quiet = 1'b0;
    wait_drained();

    rand_bytes = 0;
    while (rand_bytes < 400) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        build_datagram(16'($urandom_range(65535)), FlagData, gen_seq, $urandom_range(24), 1'b0);
        gen_seq++;
      end else if (pick < 65) begin
        build_datagram(16'($urandom_range(65535)), FlagData,
                       gen_seq + 8'd1 + 8'($urandom_range(254)), $urandom_range(24), 1'b0);
      end else if (pick < 72) begin
        build_datagram(16'($urandom_range(65535)), FlagOver, 8'($urandom_range(255)),
                       $urandom_range(24), 1'b0);
        gen_seq = '0;
      end else if (pick < 79) begin
        f = 8'($urandom_range(255));
        while (f == FlagData || f == FlagOver) f = 8'($urandom_range(255));
        build_datagram(16'($urandom_range(65535)), f, 8'($urandom_range(255)),
                       $urandom_range(24), 1'b0);
      end else if (pick < 87) begin
        build_datagram(16'($urandom_range(65535)), FlagData, gen_seq, $urandom_range(24), 1'b1);
      end else if (pick < 95) begin
        random_bytes($urandom_range(1, 5));
      end else begin
        random_bytes($urandom_range(6, 30));
      end
      send_datagram();
    end

    in_valid <= 1'b0;
    guard = 0;
    while (verdict_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end
    if (n_mismatch == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: stop_and_wait_receiver.f
hdl/saw_rx_pkg.sv
hdl/stop_and_wait_receiver.sv
tb/sv/testbench.sv
